// File: sv/playfair_cipher_engine_macros.svh
// Assertion macros for the playfair cipher engine checker.
// Expects signals named clk and rst in the scope of use.
`ifndef PLAYFAIR_CIPHER_ENGINE_MACROS_SVH
`define PLAYFAIR_CIPHER_ENGINE_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define PFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Antecedent this cycle implies consequent on the next cycle.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pfc_pkg.sv
// Shared types and constants of the playfair cipher engine.
// No dependencies.
`default_nettype none

package pfc_pkg;

  localparam int LET_W = 5;
  localparam int CELLS = 25;
  localparam int ALPHA = 26;

  localparam logic [LET_W-1:0] LET_I = 5'd8;
  localparam logic [LET_W-1:0] LET_J = 5'd9;
  localparam logic [LET_W-1:0] LET_X = 5'd23;

  typedef enum logic [1:0] {
    FN_KEY    = 2'd0,
    FN_FINISH = 2'd1,
    FN_ENC    = 2'd2,
    FN_DEC    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_ADDR,
    ST_EMIT_X,
    ST_EMIT_Y
  } state_t;

  typedef struct packed {
    logic             en;
    logic [LET_W-1:0] addr;
    logic [LET_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// File: sv/playfair_cipher_engine.sv
// Playfair cipher engine over letter codes A=0..Z=25. A key letter (tuser 0) gives no
// result; a finish beat (tuser 1) starts the square fill, during which no beat is taken.
// An encrypt or decrypt letter (tuser 2/3) that is only held gives no result; one that
// completes a digraph is looked up: the letter position RAM and then the key square RAM
// are read in turn, each with a registered read, then the two result letters (a result X
// is dropped in decrypt) leave one beat per cycle while the result side does not stall.
// The result register lets the next beat be taken while the last result waits.
// Depends on pfc_pkg, pfc_ram, pfc_sub and pfc_ctrl.
`default_nettype none

module playfair_cipher_engine
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [1:0] s_axis_tuser,   // [1:0] func
  input  wire logic       s_axis_tlast,   // text_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [4:0] out_letter, [7:5] zero
  output logic            m_axis_tlast    // run_last
);

  mem_wr_t          ks_wr, lp_wr;
  logic [LET_W-1:0] lp_raddr0, lp_raddr1, lp_rdata0, lp_rdata1;
  logic [LET_W-1:0] ks_raddr0, ks_raddr1, ks_rdata0, ks_rdata1;
  logic [LET_W-1:0] out_letter;
  logic             dec;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (s_axis_tuser),
    .in_letter (s_axis_tdata[LET_W-1:0]),
    .in_end    (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_letter(out_letter),
    .out_last  (m_axis_tlast),
    .ks_wr     (ks_wr),
    .lp_wr     (lp_wr),
    .lp_raddr0 (lp_raddr0),
    .lp_raddr1 (lp_raddr1),
    .ks_rdata0 (ks_rdata0),
    .ks_rdata1 (ks_rdata1),
    .dec       (dec)
  );

  // cell index of each placed letter
  pfc_ram #(.DEPTH(26)) u_place (
    .clk   (clk),
    .wr    (lp_wr),
    .raddr0(lp_raddr0),
    .raddr1(lp_raddr1),
    .rdata0(lp_rdata0),
    .rdata1(lp_rdata1)
  );

  pfc_sub u_sub (
    .dec(dec),
    .pa (lp_rdata0),
    .pb (lp_rdata1),
    .ia (ks_raddr0),
    .ib (ks_raddr1)
  );

  // letter in each cell, row-major
  pfc_ram #(.DEPTH(25)) u_square (
    .clk   (clk),
    .wr    (ks_wr),
    .raddr0(ks_raddr0),
    .raddr1(ks_raddr1),
    .rdata0(ks_rdata0),
    .rdata1(ks_rdata1)
  );

  assign m_axis_tdata = {3'b000, out_letter};

endmodule

`default_nettype wire

// File: sv/pfc_ram.sv
// Letter-wide synchronous RAM, one write port and two registered read ports.
// Depends on pfc_pkg.
`default_nettype none

module pfc_ram
  import pfc_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic             clk,
  input  wire mem_wr_t          wr,
  input  wire logic [LET_W-1:0] raddr0,
  input  wire logic [LET_W-1:0] raddr1,
  output logic      [LET_W-1:0] rdata0,
  output logic      [LET_W-1:0] rdata1
);

  logic [LET_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// File: sv/pfc_sub.sv
// Digraph substitution: cell positions of both letters to cell indexes of the result.
// Depends on pfc_pkg.
`default_nettype none

module pfc_sub
  import pfc_pkg::*;
(
  input  wire logic             dec,
  input  wire logic [LET_W-1:0] pa,
  input  wire logic [LET_W-1:0] pb,
  output logic      [LET_W-1:0] ia,
  output logic      [LET_W-1:0] ib
);

  function automatic logic [2:0] row_of(input logic [LET_W-1:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [LET_W-1:0] times5(input logic [2:0] r);
    return {r, 2'b00} + {2'b00, r};
  endfunction

  // one step around the square side: right/down to encrypt, left/up to decrypt
  function automatic logic [2:0] step(input logic [2:0] c, input logic d);
    logic [2:0] s;
    if (d) s = (c == 3'd0) ? 3'd4 : c - 3'd1;
    else s = (c == 3'd4) ? 3'd0 : c + 3'd1;
    return s;
  endfunction

  logic [2:0]       ra, rb, ca, cb;
  logic [LET_W-1:0] da, db;

  always_comb begin
    ra = row_of(pa);
    rb = row_of(pb);
    da = pa - times5(ra);
    db = pb - times5(rb);
    ca = da[2:0];
    cb = db[2:0];
    if (ra == rb) begin
      // also covers two letters in one cell
      ia = times5(ra) + {2'b00, step(ca, dec)};
      ib = times5(rb) + {2'b00, step(cb, dec)};
    end else if (ca == cb) begin
      ia = times5(step(ra, dec)) + {2'b00, ca};
      ib = times5(step(rb, dec)) + {2'b00, cb};
    end else begin
      ia = times5(ra) + {2'b00, cb};
      ib = times5(rb) + {2'b00, ca};
    end
  end

endmodule

`default_nettype wire

// File: sv/pfc_ctrl.sv
// Sequencer of the playfair engine: square build, digraph forming, result beats.
// Depends on pfc_pkg; drives the two RAMs and takes cell indexes through pfc_sub.
`default_nettype none

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_func,
  input  wire logic [LET_W-1:0] in_letter,
  input  wire logic             in_end,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [LET_W-1:0] out_letter,
  output logic                  out_last,
  output mem_wr_t               ks_wr,
  output mem_wr_t               lp_wr,
  output logic      [LET_W-1:0] lp_raddr0,
  output logic      [LET_W-1:0] lp_raddr1,
  input  wire logic [LET_W-1:0] ks_rdata0,
  input  wire logic [LET_W-1:0] ks_rdata1,
  output logic                  dec
);

  state_t           state, state_next;
  logic [LET_W-1:0] fill, fill_next;
  logic             done, done_next;
  logic [LET_W-1:0] held_letter, held_letter_next;
  logic             held_valid, held_valid_next;
  logic [ALPHA-1:0] used, used_next;
  logic [LET_W-1:0] k, k_next;
  logic [LET_W-1:0] a, a_next, b, b_next;
  logic             dec_next;
  logic             rep, rep_next;

  logic             place_en;
  logic [LET_W-1:0] place_let;
  logic [LET_W-1:0] fill_base;
  logic [ALPHA-1:0] used_base;
  logic             place_ok;

  logic             emit_we;
  logic [LET_W-1:0] emit_letter;
  logic             emit_last;
  logic             out_free;
  logic             skip_x, skip_y;
  func_t            fn;

  assign fn        = func_t'(in_func);
  assign out_free  = !out_valid || out_ready;
  assign skip_x    = dec && (ks_rdata0 == LET_X);
  assign skip_y    = dec && (ks_rdata1 == LET_X);
  assign lp_raddr0 = (a == LET_J) ? LET_I : a;
  assign lp_raddr1 = (b == LET_J) ? LET_I : b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      done        <= 1'b0;
      held_letter <= '0;
      held_valid  <= 1'b0;
      used        <= '0;
      k           <= '0;
      rep         <= 1'b0;
    end else begin
      state       <= state_next;
      fill        <= fill_next;
      done        <= done_next;
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
      used        <= used_next;
      k           <= k_next;
      rep         <= rep_next;
    end
  end

  always_ff @(posedge clk) begin
    a   <= a_next;
    b   <= b_next;
    dec <= dec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_we) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_we) begin
      out_letter <= emit_letter;
      out_last   <= emit_last;
    end
  end

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    done_next        = done;
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    used_next        = used;
    k_next           = k;
    a_next           = a;
    b_next           = b;
    dec_next         = dec;
    rep_next         = rep;
    in_ready         = 1'b0;
    place_en         = 1'b0;
    place_let        = in_letter;
    fill_base        = fill;
    used_base        = used;
    emit_we          = 1'b0;
    emit_letter      = ks_rdata0;
    emit_last        = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (fn)
            FN_FINISH: begin
              k_next     = '0;
              state_next = ST_FILL;
            end
            FN_KEY: begin
              if (in_letter < LET_W'(ALPHA)) begin
                place_en = 1'b1;
                if (done) begin
                  // a key letter after a finished square opens a new key
                  used_base       = '0;
                  fill_base       = '0;
                  done_next       = 1'b0;
                  held_valid_next = 1'b0;
                end
              end
            end
            default: begin
              if (in_letter < LET_W'(ALPHA) && done) begin
                dec_next = (fn == FN_DEC);
                rep_next = 1'b0;
                if (!held_valid) begin
                  if (in_end) begin
                    a_next     = in_letter;
                    b_next     = LET_X;
                    state_next = ST_LOOK;
                  end else begin
                    held_letter_next = in_letter;
                    held_valid_next  = 1'b1;
                  end
                end else if (fn != FN_DEC && held_letter == in_letter) begin
                  // doubled letter (encrypt only): pad with X, second copy stays held unless it ends the text
                  a_next     = in_letter;
                  b_next     = LET_X;
                  rep_next   = in_end;
                  state_next = ST_LOOK;
                  if (in_end) begin
                    held_valid_next = 1'b0;
                  end
                end else begin
                  a_next          = held_letter;
                  b_next          = in_letter;
                  held_valid_next = 1'b0;
                  state_next      = ST_LOOK;
                end
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        place_en  = 1'b1;
        place_let = k;
        k_next    = k + 1'b1;
        if (k == LET_W'(ALPHA - 1)) begin
          done_next       = 1'b1;
          held_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      ST_LOOK: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        state_next = ST_EMIT_X;
      end
      ST_EMIT_X: begin
        if (skip_x) begin
          state_next = ST_EMIT_Y;
        end else if (out_free) begin
          emit_we     = 1'b1;
          emit_letter = ks_rdata0;
          emit_last   = !rep && skip_y;
          state_next  = ST_EMIT_Y;
        end
      end
      ST_EMIT_Y: begin
        if (skip_y || out_free) begin
          emit_we     = !skip_y;
          emit_letter = ks_rdata1;
          emit_last   = !rep;
          if (rep) begin
            // doubled final letter: same digraph goes out a second time
            rep_next   = 1'b0;
            state_next = ST_EMIT_X;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    place_ok = place_en && (place_let != LET_J) && !used_base[place_let] &&
               (fill_base < LET_W'(CELLS));
    if (place_en) begin
      used_next = used_base;
      fill_next = fill_base;
      if (place_ok) begin
        used_next = used_base | (ALPHA'(1) << place_let);
        fill_next = fill_base + 1'b1;
      end
    end
  end

  always_comb begin
    ks_wr.en   = place_ok;
    ks_wr.addr = fill_base;
    ks_wr.data = place_let;
    lp_wr.en   = place_ok;
    lp_wr.addr = place_let;
    lp_wr.data = fill_base;
  end

endmodule

`default_nettype wire

// File: sv/pfc_checker.sv
// Port-level checks of the playfair cipher engine, bound to the top level.
// Depends on pfc_pkg and playfair_cipher_engine_macros.svh.
`default_nettype none
`include "playfair_cipher_engine_macros.svh"

module pfc_checker
  import pfc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [1:0] s_axis_tuser,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // stalled result beat holds
  `PFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")
  // results are letters only
  `PFC_ASSERT(a_out_range, !m_axis_tvalid || (m_axis_tdata[4:0] <= 5'd25 && m_axis_tdata[7:5] == 3'd0), "result letter out of range")
  // the square fill blocks input
  `PFC_ASSERT_NEXT(a_fill_busy, in_beat && s_axis_tuser == FN_FINISH, !s_axis_tready, "beat taken during square fill")
  // a key letter produces no result and leaves the input ready on the next cycle
  `PFC_ASSERT_NEXT(a_key_quiet, in_beat && s_axis_tuser == FN_KEY && !m_axis_tvalid, s_axis_tready && !m_axis_tvalid, "key letter caused a result or a stall")

endmodule

bind playfair_cipher_engine pfc_checker u_pfc_checker (.*);

`default_nettype wire
